FILE: rtl/pqt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_pkg
// shared widths, codes and controller/datapath interface types for the
// partition quota tracker
// ----------------------------------------------------------------------------
package pqt_pkg;

    localparam int DEF_NUM_ELEMENTS = 64;
    localparam int DEF_NUM_GROUPS   = 8;

    localparam int NUM_LIMITS = 8;
    localparam int CMD_W      = 3;
    localparam int ELEM_W     = 6;
    localparam int GROUP_W    = 3;
    localparam int LIMIT_W    = 7;
    localparam int COUNT_W    = 7;
    localparam int ERR_W      = 2;
    localparam int CFG_IDX_W  = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_MAP        = 3'd0,
        CMD_ADD        = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_CAN_ADD    = 3'd3,
        CMD_CAN_SWAP   = 3'd4,
        CMD_LIST_SWAPS = 3'd5,
        CMD_CLEAR      = 3'd6,
        CMD_IS_MEMBER  = 3'd7
    } cmd_e;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 2'd0,
        ERR_ALREADY    = 2'd1,
        ERR_NOT_MEMBER = 2'd2,
        ERR_UNMAPPED   = 2'd3
    } err_e;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec_emit;
        logic scan_start;
        logic scan_read;
        logic scan_step;
        logic take_match;
        logic emit_pend;
        logic flush_emit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic list_go;
        logic scan_member;
        logic match;
        logic pend_valid;
        logic scan_end;
    } dp_status_t;

endpackage

FILE: rtl/pqt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_ctrl
// sequencer: takes a word, runs the command, walks members for a swap list
// ----------------------------------------------------------------------------
module pqt_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  pqt_pkg::dp_status_t   status,
    output pqt_pkg::ctrl_cmd_t    ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_CHECK,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg, stall_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.list_go)
                begin
                    ctrl.scan_start = 1'b1;
                    state_next      = ST_SCAN;
                end
                else if (status.out_free)
                begin
                    ctrl.exec_emit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_member)
                begin
                    ctrl.scan_read = 1'b1;
                    state_next     = ST_CHECK;
                end
                else
                begin
                    ctrl.scan_step = 1'b1;
                    state_next     = status.scan_end ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_CHECK:
            begin
                if (!status.match)
                begin
                    ctrl.scan_step = 1'b1;
                    state_next     = status.scan_end ? ST_FLUSH : ST_SCAN;
                end
                else if (!status.pend_valid || status.out_free)
                begin
                    // older match goes out, this one becomes the held entry
                    ctrl.take_match = 1'b1;
                    ctrl.emit_pend  = status.pend_valid;
                    ctrl.scan_step  = 1'b1;
                    state_next      = status.scan_end ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    ctrl.flush_emit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
        endcase
        stall_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign item_stall = stall_reg;

endmodule

FILE: rtl/pqt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_datapath
// group map memory, membership and map flags, group counts, limits,
// scan pointer and output register
// ----------------------------------------------------------------------------
module pqt_datapath #(
    parameter int NUM_ELEMENTS = pqt_pkg::DEF_NUM_ELEMENTS,
    parameter int NUM_GROUPS   = pqt_pkg::DEF_NUM_GROUPS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [pqt_pkg::CMD_W-1:0]           command,
    input  logic [pqt_pkg::ELEM_W-1:0]          element,
    input  logic [pqt_pkg::ELEM_W-1:0]          partner,
    input  logic [pqt_pkg::GROUP_W-1:0]         group_id,
    input  logic                                cfg_valid,
    input  logic [pqt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pqt_pkg::LIMIT_W-1:0]         cfg_data,
    input  pqt_pkg::ctrl_cmd_t                  ctrl,
    output pqt_pkg::dp_status_t                 status,
    input  logic                                result_stall,
    output logic                                result_valid,
    output logic                                answer,
    output logic [pqt_pkg::ELEM_W-1:0]          listed_member,
    output logic                                member_valid,
    output logic                                last,
    output logic [pqt_pkg::ERR_W-1:0]           error_code,
    output logic                                all_within_limits
);

    localparam int IDX_W  = $clog2(NUM_ELEMENTS);
    localparam int GIDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int EW     = pqt_pkg::ELEM_W;
    localparam int CW1    = pqt_pkg::COUNT_W + 1;
    localparam int LW     = pqt_pkg::CFG_IDX_W;

    // captured word
    logic [pqt_pkg::CMD_W-1:0]   cmd_reg;
    logic [pqt_pkg::ELEM_W-1:0]  elem_reg;
    logic [pqt_pkg::ELEM_W-1:0]  partner_reg;
    logic [pqt_pkg::GROUP_W-1:0] gid_reg;

    // group map memory with registered reads
    logic [pqt_pkg::GROUP_W-1:0] group_mem [NUM_ELEMENTS];
    logic [pqt_pkg::GROUP_W-1:0] rd_a_reg;
    logic [pqt_pkg::GROUP_W-1:0] rd_b_reg;
    logic                        mem_we;

    logic [NUM_ELEMENTS-1:0]     mapped_reg, mapped_next;
    logic [NUM_ELEMENTS-1:0]     member_reg, member_next;
    logic [pqt_pkg::COUNT_W-1:0] count_reg  [NUM_GROUPS];
    logic [pqt_pkg::COUNT_W-1:0] count_next [NUM_GROUPS];
    logic [pqt_pkg::LIMIT_W-1:0] limit_reg  [pqt_pkg::NUM_LIMITS];

    logic [IDX_W-1:0]            scan_idx_reg;
    logic [pqt_pkg::GROUP_W-1:0] scan_group_reg;
    logic                        scan_any_reg;
    logic                        pend_valid_reg;
    logic [IDX_W-1:0]            pend_idx_reg;

    logic                        result_valid_reg;
    logic                        answer_reg;
    logic [pqt_pkg::ELEM_W-1:0]  listed_reg;
    logic                        mvalid_reg;
    logic                        last_reg;
    logic [pqt_pkg::ERR_W-1:0]   err_reg;
    logic                        all_ok_reg;

    // decode
    logic              e_ok, p_ok, g_ok, e_map, e_mem, p_mem, room;
    logic [IDX_W-1:0]  e_idx, p_idx;
    logic [GIDX_W-1:0] ge_idx;
    pqt_pkg::err_e     err;
    logic              ans, map_go, add_go, rem_go, clr_go, list_go;
    logic              all_ok;
    logic              emit, out_free;

    always_comb
    begin
        e_ok   = 32'(elem_reg) < NUM_ELEMENTS;
        p_ok   = 32'(partner_reg) < NUM_ELEMENTS;
        g_ok   = 32'(gid_reg) < NUM_GROUPS;
        e_idx  = IDX_W'(elem_reg);
        p_idx  = IDX_W'(partner_reg);
        e_map  = e_ok && mapped_reg[e_idx];
        e_mem  = e_ok && member_reg[e_idx];
        p_mem  = p_ok && member_reg[p_idx];
        ge_idx = GIDX_W'(rd_a_reg);
        room   = (CW1'(count_reg[ge_idx]) + CW1'(1)) <= CW1'(limit_reg[rd_a_reg]);

        err     = pqt_pkg::ERR_OK;
        ans     = 1'b0;
        map_go  = 1'b0;
        add_go  = 1'b0;
        rem_go  = 1'b0;
        clr_go  = 1'b0;
        list_go = 1'b0;
        unique case (pqt_pkg::cmd_e'(cmd_reg))
            pqt_pkg::CMD_MAP:
            begin
                if (!e_ok || !g_ok)  err = pqt_pkg::ERR_UNMAPPED;
                else if (e_mem)      err = pqt_pkg::ERR_ALREADY;
                else                 map_go = 1'b1;
            end
            pqt_pkg::CMD_ADD:
            begin
                if (!e_map)          err = pqt_pkg::ERR_UNMAPPED;
                else if (e_mem)      err = pqt_pkg::ERR_ALREADY;
                else                 add_go = 1'b1;
            end
            pqt_pkg::CMD_REMOVE:
            begin
                if (!e_map)          err = pqt_pkg::ERR_UNMAPPED;
                else if (!e_mem)     err = pqt_pkg::ERR_NOT_MEMBER;
                else                 rem_go = 1'b1;
            end
            pqt_pkg::CMD_CAN_ADD:
            begin
                if (!e_map)          err = pqt_pkg::ERR_UNMAPPED;
                else if (e_mem)      err = pqt_pkg::ERR_ALREADY;
                else                 ans = room;
            end
            pqt_pkg::CMD_CAN_SWAP:
            begin
                if (!e_map)          err = pqt_pkg::ERR_UNMAPPED;
                else if (e_mem)      err = pqt_pkg::ERR_ALREADY;
                else if (!p_mem)     err = pqt_pkg::ERR_NOT_MEMBER;
                else                 ans = room || (rd_a_reg == rd_b_reg);
            end
            pqt_pkg::CMD_LIST_SWAPS:
            begin
                if (!e_map)          err = pqt_pkg::ERR_UNMAPPED;
                else if (e_mem)      err = pqt_pkg::ERR_ALREADY;
                else                 list_go = 1'b1;
            end
            pqt_pkg::CMD_CLEAR:
            begin
                clr_go = 1'b1;
            end
            pqt_pkg::CMD_IS_MEMBER:
            begin
                ans = e_mem;
            end
        endcase
    end

    // state update, only on the single-result path
    always_comb
    begin
        mapped_next = mapped_reg;
        member_next = member_reg;
        if (ctrl.exec_emit)
        begin
            if (map_go)  mapped_next[e_idx] = 1'b1;
            if (add_go)  member_next[e_idx] = 1'b1;
            if (rem_go)  member_next[e_idx] = 1'b0;
            if (clr_go)  member_next = '0;
        end
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            count_next[g] = count_reg[g];
            if (ctrl.exec_emit && clr_go)
                count_next[g] = '0;
            else if (ctrl.exec_emit && add_go && (ge_idx == GIDX_W'(g)))
                count_next[g] = count_reg[g] + 1'b1;
            else if (ctrl.exec_emit && rem_go && (ge_idx == GIDX_W'(g)))
                count_next[g] = count_reg[g] - 1'b1;
        end
        all_ok = 1'b1;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (count_next[g] > limit_reg[LW'(g)])
                all_ok = 1'b0;
        end
    end

    assign mem_we   = ctrl.exec_emit && map_go;
    assign out_free = !result_valid_reg || !result_stall;
    assign emit     = ctrl.exec_emit || ctrl.emit_pend || ctrl.flush_emit;

    always_comb
    begin
        status.out_free    = out_free;
        status.list_go     = list_go;
        status.scan_member = member_reg[scan_idx_reg];
        status.match       = member_reg[scan_idx_reg]
                             && (scan_any_reg || (rd_a_reg == scan_group_reg));
        status.pend_valid  = pend_valid_reg;
        status.scan_end    = (scan_idx_reg == IDX_W'(NUM_ELEMENTS - 1));
    end

    // captured word
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg     <= command;
            elem_reg    <= element;
            partner_reg <= partner;
            gid_reg     <= group_id;
        end
    end

    // group map memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            group_mem[e_idx] <= gid_reg;
        if (ctrl.capture)
        begin
            rd_a_reg <= group_mem[IDX_W'(element)];
            rd_b_reg <= group_mem[IDX_W'(partner)];
        end
        else if (ctrl.scan_read)
        begin
            rd_a_reg <= group_mem[scan_idx_reg];
        end
    end

    // flags, counts, limits, scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapped_reg     <= '0;
            member_reg     <= '0;
            for (int g = 0; g < NUM_GROUPS; g++)
                count_reg[g] <= '0;
            for (int k = 0; k < pqt_pkg::NUM_LIMITS; k++)
                limit_reg[k] <= pqt_pkg::LIMIT_RESET;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            mapped_reg <= mapped_next;
            member_reg <= member_next;
            for (int g = 0; g < NUM_GROUPS; g++)
                count_reg[g] <= count_next[g];
            if (cfg_valid)
                limit_reg[cfg_index] <= cfg_data;
            if (ctrl.scan_start)
            begin
                scan_idx_reg   <= '0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (ctrl.scan_step && !status.scan_end)
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                if (ctrl.take_match)
                    pend_valid_reg <= 1'b1;
            end
            if (emit)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // scan payload
    always_ff @(posedge clk)
    begin
        if (ctrl.scan_start)
        begin
            scan_group_reg <= rd_a_reg;
            scan_any_reg   <= room;
        end
        if (ctrl.take_match)
            pend_idx_reg <= scan_idx_reg;
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (ctrl.exec_emit)
        begin
            answer_reg <= ans;
            listed_reg <= '0;
            mvalid_reg <= 1'b0;
            last_reg   <= 1'b1;
            err_reg    <= err;
            all_ok_reg <= all_ok;
        end
        else if (ctrl.emit_pend)
        begin
            answer_reg <= 1'b0;
            listed_reg <= EW'(pend_idx_reg);
            mvalid_reg <= 1'b1;
            last_reg   <= 1'b0;
            err_reg    <= pqt_pkg::ERR_OK;
            all_ok_reg <= all_ok;
        end
        else if (ctrl.flush_emit)
        begin
            answer_reg <= 1'b0;
            listed_reg <= pend_valid_reg ? EW'(pend_idx_reg) : '0;
            mvalid_reg <= pend_valid_reg;
            last_reg   <= 1'b1;
            err_reg    <= pqt_pkg::ERR_OK;
            all_ok_reg <= all_ok;
        end
    end

    assign result_valid      = result_valid_reg;
    assign answer            = answer_reg;
    assign listed_member     = listed_reg;
    assign member_valid      = mvalid_reg;
    assign last              = last_reg;
    assign error_code        = err_reg;
    assign all_within_limits = all_ok_reg;

endmodule

FILE: rtl/partition_quota_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_quota_tracker
// selected-set tracker with per-group count limits (partition matroid oracle)
// ----------------------------------------------------------------------------
// usage
//   item channel: item_valid / item_stall carry one command word (command,
//   element, partner, group_id); a word is taken when valid is high and
//   stall is low.
//   result channel: result_valid / result_stall carry one result word; a
//   command gives one word, list_swaps gives one word per listed member with
//   last set on the final one, or one empty closing word if none is listed.
//   cfg channel: cfg_valid / cfg_ready write limit_group<cfg_index>; ready is
//   always high, writes are meant for idle periods only.
//   a result word is offered from the output register once the execute state
//   has run; ordinary commands go one at a time: the registered read of the
//   group map memory, then the execute state, then back to idle for the next.
//   list_swaps runs the execute state, a walk over every element, one more
//   memory read per member and a final flush.
//   a stalled receiver holds the output register; the block takes at most one
//   more word, then waits in execute, in the member walk or in the final flush
//   until the held word is gone.
//   reset clears the set, the map flags, the counts and loads all limits with
//   64; the group map memory itself is not cleared.
// ----------------------------------------------------------------------------
module partition_quota_tracker #(
    parameter int NUM_ELEMENTS = pqt_pkg::DEF_NUM_ELEMENTS,
    parameter int NUM_GROUPS   = pqt_pkg::DEF_NUM_GROUPS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // command words
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [pqt_pkg::CMD_W-1:0]      command,
    input  logic [pqt_pkg::ELEM_W-1:0]     element,
    input  logic [pqt_pkg::ELEM_W-1:0]     partner,
    input  logic [pqt_pkg::GROUP_W-1:0]    group_id,
    // result words
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           answer,
    output logic [pqt_pkg::ELEM_W-1:0]     listed_member,
    output logic                           member_valid,
    output logic                           last,
    output logic [pqt_pkg::ERR_W-1:0]      error_code,
    output logic                           all_within_limits,
    // limit registers
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pqt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pqt_pkg::LIMIT_W-1:0]    cfg_data
);

    pqt_pkg::ctrl_cmd_t  ctrl;
    pqt_pkg::dp_status_t status;

    // limit writes go straight into the limit registers, nothing to back-pressure
    assign cfg_ready = 1'b1;

    // sequencer: idle / execute / member walk / final flush
    pqt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .ctrl       (ctrl)
    );

    // storage, checks and the output register
    pqt_datapath #(
        .NUM_ELEMENTS (NUM_ELEMENTS),
        .NUM_GROUPS   (NUM_GROUPS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .command           (command),
        .element           (element),
        .partner           (partner),
        .group_id          (group_id),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .ctrl              (ctrl),
        .status            (status),
        .result_stall      (result_stall),
        .result_valid      (result_valid),
        .answer            (answer),
        .listed_member     (listed_member),
        .member_valid      (member_valid),
        .last              (last),
        .error_code        (error_code),
        .all_within_limits (all_within_limits)
    );

`ifndef SYNTHESIS
    // a taken word always blocks the next cycle while it executes
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("item channel not busy after a word was taken");

    // a word without a listed member always closes its command
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !member_valid) |-> last)
        else $error("non-list result word without last");

    // an error word is a single closing word with no listed member
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (error_code != pqt_pkg::ERR_OK)) |-> (last && !member_valid))
        else $error("error word is not a single closing word");

    // list entries never carry a yes answer
    a_list_no_answer: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(answer && member_valid))
        else $error("answer set on a listed member");
`endif

endmodule
